### hw/rtl/dls_pkg.sv
// Shared types and constants of the DHCP lease server.
package dls_pkg;

  localparam int unsigned LeaseSlots = 32;

  localparam logic [7:0] MsgDiscover = 8'd1;
  localparam logic [7:0] MsgRequest  = 8'd3;
  localparam logic [7:0] MsgDecline  = 8'd4;
  localparam logic [7:0] MsgRelease  = 8'd7;
  localparam logic [7:0] MsgInform   = 8'd8;

  localparam logic [1:0] KindOffer = 2'd0;
  localparam logic [1:0] KindAck   = 2'd1;
  localparam logic [1:0] KindNak   = 2'd2;

  localparam logic [1:0] RegServerIp  = 2'd0;
  localparam logic [1:0] RegPoolStart = 2'd1;
  localparam logic [1:0] RegPoolSize  = 2'd2;
  localparam logic [1:0] RegLeaseMs   = 2'd3;

  // Scan performed by the datapath on the slot table.
  typedef enum logic [2:0] {
    ScanNone,
    ScanMac,      // find used slot holding client MAC
    ScanAddr,     // is candidate address taken
    ScanFree,     // find first free slot
    ScanExpire    // free overdue slots
  } scan_e;

  typedef struct packed {
    logic        start;     // begin a scan, one cycle
    scan_e       kind;
    logic [31:0] addr;      // candidate for ScanAddr
    logic        claim;     // write MAC/addr/expiry into hit slot
    logic        touch;     // rewrite expiry of hit slot
    logic        free;      // clear used bit of hit slot
  } dp_cmd_t;

  typedef struct packed {
    logic        done;      // scan finished, pulse
    logic        hit;
    logic [31:0] hit_addr;  // address stored in hit slot
  } dp_sts_t;

  typedef enum logic [3:0] {
    StIdle,
    StFindMac,
    StWantChk,
    StWantFree,
    StScanChk,
    StScanFree,
    StCheckReq,
    StExpire,
    StOut
  } ctl_state_e;

endpackage

### hw/rtl/dls_ram.sv
// Generic single-port RAM with registered read.
module dls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                           wdata_i,
  output logic [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hw/rtl/dls_datapath.sv
// Lease table datapath: slot memories, used bits and the sequential slot scan.
module dls_datapath #(
  parameter int unsigned LeaseSlots = dls_pkg::LeaseSlots
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dls_pkg::dp_cmd_t cmd_i,
  input  logic [47:0]      mac_i,
  input  logic [31:0]      now_i,
  input  logic [31:0]      lease_ms_i,
  input  logic [31:0]      server_ip_i,
  output dls_pkg::dp_sts_t sts_o
);
  import dls_pkg::*;

  localparam int unsigned IdxW = (LeaseSlots > 1) ? $clog2(LeaseSlots) : 1;
  localparam int unsigned CntW = $clog2(LeaseSlots + 1);

  logic [LeaseSlots-1:0] used_q, used_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  busy_q, busy_d;
  logic                  rd_q, rd_d;         // read data valid for slot idx_q-1
  logic [IdxW-1:0]       ridx_q, ridx_d;
  logic                  hit_q, hit_d;
  logic [IdxW-1:0]       hidx_q, hidx_d;
  logic [31:0]           haddr_q, haddr_d;
  logic                  done_q, done_d;
  scan_e                 kind_q, kind_d;
  logic [31:0]           cand_q, cand_d;

  logic                  we;
  logic [IdxW-1:0]       ram_addr;
  logic [47:0]           mac_rd;
  logic [31:0]           addr_rd, exp_rd, exp_wd, diff;

  assign exp_wd = now_i + lease_ms_i;
  assign diff   = now_i - exp_rd;

  // Memory writes only on claim/touch of the hit slot.
  always_comb begin
    we       = 1'b0;
    ram_addr = idx_q[IdxW-1:0];
    if (!busy_q && (cmd_i.claim || cmd_i.touch)) begin
      we       = 1'b1;
      ram_addr = hidx_q;
    end
  end

  dls_ram #(.Width(48), .Depth(LeaseSlots)) u_mac (
    .clk_i, .we_i(we && cmd_i.claim), .addr_i(ram_addr), .wdata_i(mac_i), .rdata_o(mac_rd));
  dls_ram #(.Width(32), .Depth(LeaseSlots)) u_addr (
    .clk_i, .we_i(we && cmd_i.claim), .addr_i(ram_addr), .wdata_i(cand_q),
    .rdata_o(addr_rd));
  dls_ram #(.Width(32), .Depth(LeaseSlots)) u_exp (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(exp_wd), .rdata_o(exp_rd));

  always_comb begin
    used_d  = used_q;
    idx_d   = idx_q;
    busy_d  = busy_q;
    rd_d    = 1'b0;
    ridx_d  = ridx_q;
    hit_d   = hit_q;
    hidx_d  = hidx_q;
    haddr_d = haddr_q;
    done_d  = 1'b0;
    kind_d  = kind_q;
    cand_d  = cand_q;

    if (!busy_q) begin
      if (cmd_i.claim) begin
        used_d[hidx_q] = 1'b1;
        haddr_d        = cand_q;
      end
      if (cmd_i.free) begin
        used_d[hidx_q] = 1'b0;
      end
      if (cmd_i.start) begin
        busy_d = 1'b1;
        idx_d  = '0;
        hit_d  = 1'b0;
        kind_d = cmd_i.kind;
        cand_d = cmd_i.addr;
        if (cmd_i.kind == ScanAddr && cmd_i.addr == server_ip_i) begin
          hit_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end else begin
      // Stage 1: check read data of previous slot.
      if (rd_q && !hit_q) begin
        unique case (kind_q)
          ScanMac: if (used_q[ridx_q] && mac_rd == mac_i) begin
            hit_d = 1'b1; hidx_d = ridx_q; haddr_d = addr_rd;
          end
          ScanAddr: if (used_q[ridx_q] && addr_rd == cand_q) hit_d = 1'b1;
          ScanExpire: if (used_q[ridx_q] && !diff[31]) used_d[ridx_q] = 1'b0;
          default: ;
        endcase
      end
      // Stage 0: issue next read, or finish.
      if (hit_d && kind_q != ScanExpire) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (kind_q == ScanFree) begin
        if (idx_q == CntW'(LeaseSlots)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else if (!used_q[idx_q[IdxW-1:0]]) begin
          hit_d  = 1'b1;
          hidx_d = idx_q[IdxW-1:0];
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end else if (idx_q == CntW'(LeaseSlots)) begin
        if (!rd_q) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        rd_d   = 1'b1;
        ridx_d = idx_q[IdxW-1:0];
        idx_d  = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      busy_q <= 1'b0;
      rd_q   <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      idx_q  <= '0;
      kind_q <= ScanNone;
    end else begin
      used_q <= used_d;
      busy_q <= busy_d;
      rd_q   <= rd_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= ridx_d;
    hidx_q  <= hidx_d;
    haddr_q <= haddr_d;
    cand_q  <= cand_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.hit_addr = haddr_q;
endmodule

### hw/rtl/dls_ctrl.sv
// Request sequencer: decodes a request and drives the table scans.
module dls_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [7:0]       msg_type_i,
  input  logic [31:0]      requested_ip_i,
  input  logic [31:0]      server_id_i,
  input  logic [31:0]      client_ip_i,
  input  logic [31:0]      server_ip_i,
  input  logic [31:0]      pool_start_i,
  input  logic [7:0]       pool_size_i,
  input  dls_pkg::dp_sts_t sts_i,
  output dls_pkg::dp_cmd_t cmd_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       reply_kind_o,
  output logic [31:0]      your_ip_o
);
  import dls_pkg::*;

  ctl_state_e  state_q, state_d;
  logic        issued_q, issued_d;  // scan of this state started
  logic        isreq_q, isreq_d;
  logic [31:0] want_q, want_d;
  logic [8:0]  off_q, off_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] yip_q, yip_d;
  logic [31:0] cand;
  logic [7:0]  first, bound, last;
  logic        in_pool;

  assign cand  = {pool_start_i[31:8], pool_start_i[7:0] + off_q[7:0]};
  assign first = pool_start_i[7:0];
  assign bound = first + pool_size_i;
  assign last  = want_q[7:0];
  assign in_pool = (want_q[31:8] == pool_start_i[31:8]) && last >= first && last < bound;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign reply_kind_o = kind_q;
  assign your_ip_o    = yip_q;

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    isreq_d  = isreq_q;
    want_d   = want_q;
    off_d    = off_q;
    kind_d   = kind_q;
    yip_d    = yip_q;
    cmd_o    = '0;
    cmd_o.kind = ScanNone;

    unique case (state_q)
      StIdle: if (in_valid_i) begin
        issued_d = 1'b0;
        isreq_d  = (msg_type_i == MsgRequest);
        want_d   = (msg_type_i == MsgRequest && requested_ip_i == '0) ? client_ip_i
                                                                       : requested_ip_i;
        off_d    = '0;
        if (!cmd_i) begin
          state_d = StExpire;
        end else begin
          unique case (msg_type_i)
            MsgDiscover, MsgDecline, MsgRelease: state_d = StFindMac;
            MsgRequest: if (server_id_i == '0 || server_id_i == server_ip_i)
              state_d = StFindMac;
            MsgInform: begin
              kind_d  = KindAck;
              yip_d   = client_ip_i;
              state_d = StOut;
            end
            default: ;
          endcase
        end
      end
      StExpire: begin
        cmd_o.start = !issued_q;
        cmd_o.kind  = ScanExpire;
        issued_d    = 1'b1;
        if (issued_q && sts_i.done) state_d = StIdle;
      end
      StFindMac: begin
        cmd_o.start = !issued_q;
        cmd_o.kind  = ScanMac;
        issued_d    = 1'b1;
        if (issued_q && sts_i.done) begin
          issued_d = 1'b0;
          if (msg_type_i == MsgDecline || msg_type_i == MsgRelease) begin
            cmd_o.free = sts_i.hit;
            state_d    = StIdle;
          end else if (sts_i.hit) begin
            state_d = StCheckReq;
          end else if (want_q != '0 && in_pool) begin
            state_d = StWantChk;
          end else begin
            state_d = StScanChk;
          end
        end
      end
      StWantChk: begin
        cmd_o.start = !issued_q;
        cmd_o.kind  = ScanAddr;
        cmd_o.addr  = want_q;
        issued_d    = 1'b1;
        if (issued_q && sts_i.done) begin
          issued_d = 1'b0;
          state_d  = sts_i.hit ? StScanChk : StWantFree;
        end
      end
      StWantFree, StScanFree: begin
        cmd_o.start = !issued_q;
        cmd_o.kind  = ScanFree;
        cmd_o.addr  = (state_q == StWantFree) ? want_q : cand;
        issued_d    = 1'b1;
        if (issued_q && sts_i.done) begin
          issued_d = 1'b0;
          if (sts_i.hit) begin
            cmd_o.claim = 1'b1;
            state_d     = StCheckReq;
          end else if (state_q == StWantFree) begin
            state_d = StScanChk;
          end else begin
            state_d = StCheckReq;   // table full
          end
        end
      end
      StScanChk: begin
        if (off_q >= {1'b0, pool_size_i}) begin
          // pool exhausted, nothing claimed; last scan hit may still be set
          issued_d = 1'b0;
          if (isreq_q) begin
            kind_d = KindNak; yip_d = '0; state_d = StOut;
          end else begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.start = !issued_q;
          cmd_o.kind  = ScanAddr;
          cmd_o.addr  = cand;
          issued_d    = 1'b1;
          if (issued_q && sts_i.done) begin
            issued_d = 1'b0;
            if (sts_i.hit) off_d = off_q + 1'b1;
            else state_d = StScanFree;
          end
        end
      end
      StCheckReq: begin
        // sts_i.hit still reflects the last scan: slot found, claimed or not.
        if (!sts_i.hit) begin
          if (isreq_q) begin
            kind_d = KindNak; yip_d = '0; state_d = StOut;
          end else begin
            state_d = StIdle;
          end
        end else if (isreq_q && want_q != '0 && want_q != sts_i.hit_addr) begin
          kind_d = KindNak; yip_d = '0; state_d = StOut;
        end else begin
          cmd_o.touch = 1'b1;
          kind_d  = isreq_q ? KindAck : KindOffer;
          yip_d   = sts_i.hit_addr;
          state_d = StOut;
        end
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    isreq_q <= isreq_d;
    want_q  <= want_d;
    off_q   <= off_d;
    kind_q  <= kind_d;
    yip_q   <= yip_d;
  end
endmodule

### hw/rtl/dhcp_lease_server_top.sv
// Top level of the DHCP lease server.
// One request at a time. A tick runs one expiry scan over the lease table; a request runs a MAC
// scan over the lease table and, when it must allocate, a check of the wanted address, one table
// scan per pool candidate tried and a free-slot search. s_axis_tready is low while a request is
// in work or its reply waits. Request fields are captured at acceptance, so the source need not
// hold them afterwards.
module dhcp_lease_server_top #(
  parameter int unsigned LEASE_SLOTS = dls_pkg::LeaseSlots
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] now_ms, [39:32] msg_type, [87:40] client_mac, [119:88] requested_ip,
  // [151:120] server_id, [183:152] client_ip, [215:184] transaction_id
  input  logic [215:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] your_ip, [79:32] reply_mac, [111:80] reply_xid
  output logic [111:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] reply_kind
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import dls_pkg::*;

  logic [31:0] server_ip_q, pool_start_q, lease_ms_q;
  logic [7:0]  pool_size_q;
  logic [215:0] req_q;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic [31:0] your_ip;
  logic        in_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_ip_q  <= '0;
      pool_start_q <= '0;
      pool_size_q  <= '0;
      lease_ms_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegServerIp:  server_ip_q  <= cfg_data_i;
        RegPoolStart: pool_start_q <= cfg_data_i;
        RegPoolSize:  pool_size_q  <= cfg_data_i[7:0];
        RegLeaseMs:   lease_ms_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the request so the source may move on.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) req_q <= s_axis_tdata;
  end

  assign s_axis_tready = in_ready;

  dls_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(in_ready),
    .cmd_i(s_axis_tuser),
    .msg_type_i(in_ready ? s_axis_tdata[39:32] : req_q[39:32]),
    .requested_ip_i(s_axis_tdata[119:88]),
    .server_id_i(s_axis_tdata[151:120]),
    .client_ip_i(s_axis_tdata[183:152]),
    .server_ip_i(server_ip_q), .pool_start_i(pool_start_q), .pool_size_i(pool_size_q),
    .sts_i(dp_sts), .cmd_o(dp_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .reply_kind_o(m_axis_tuser), .your_ip_o(your_ip)
  );

  dls_datapath #(.LeaseSlots(LEASE_SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(dp_cmd), .mac_i(req_q[87:40]), .now_i(req_q[31:0]),
    .lease_ms_i(lease_ms_q), .server_ip_i(server_ip_q), .sts_o(dp_sts)
  );

  assign m_axis_tdata = {req_q[215:184], req_q[87:40], your_ip};
endmodule

### bench/tb_dhcp_lease_server_top.sv
// Self-checking testbench for the DHCP lease server top level.
`timescale 1ns / 100ps

module tb_dhcp_lease_server_top;
  import dls_pkg::*;

  localparam int unsigned Slots = LeaseSlots;
  // settle time for the worst request, with a table scan for every pool candidate
  localparam int unsigned SettleCycles = 258 * (Slots + 3) + 100;
  localparam int unsigned LongStall = 2000;
  localparam int unsigned WatchdogLimit = 60000;

  typedef struct {
    logic        cmd;
    logic [31:0] now;
    logic [7:0]  mt;
    logic [47:0] mac;
    logic [31:0] req;
    logic [31:0] sid;
    logic [31:0] ci;
    logic [31:0] xid;
  } dhcp_msg_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] xid;
  } reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  dhcp_lease_server_top dut (.*);

  always #5 clk_i = ~clk_i;

  // register shadow and lease table of the predictor
  logic [31:0] srv_ip, pool_base, lease_len;
  logic [7:0]  pool_cnt;
  bit          lease_used [Slots];
  logic [47:0] lease_mac [Slots];
  logic [31:0] lease_addr [Slots];
  logic [31:0] lease_exp [Slots];

  reply_t      due_replies [$];
  int          n_err, n_sent, n_replies, n_naks;
  bit          rx_hold, quiet;
  logic [31:0] clock_ms;
  logic [47:0] mac_set [40];
  reply_t      last_reply;
  bit          last_had_reply;

  function automatic int find_client(logic [47:0] mac);
    for (int i = 0; i < Slots; i++)
      if (lease_used[i] && lease_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic bit pool_holds(logic [31:0] ip);
    logic [7:0] bound;
    bound = pool_base[7:0] + pool_cnt;
    if (ip[31:8] != pool_base[31:8]) return 0;
    return ip[7:0] >= pool_base[7:0] && ip[7:0] < bound;
  endfunction

  function automatic bit addr_busy(logic [31:0] ip);
    if (ip == srv_ip) return 1;
    for (int i = 0; i < Slots; i++)
      if (lease_used[i] && lease_addr[i] == ip) return 1;
    return 0;
  endfunction

  function automatic int take_slot(logic [47:0] mac, logic [31:0] ip, logic [31:0] now);
    for (int i = 0; i < Slots; i++)
      if (!lease_used[i]) begin
        lease_used[i] = 1;
        lease_mac[i] = mac;
        lease_addr[i] = ip;
        lease_exp[i] = now + lease_len;
        return i;
      end
    return -1;
  endfunction

  function automatic int assign_lease(logic [47:0] mac, logic [31:0] pref, logic [31:0] now);
    int s;
    logic [31:0] cand;
    s = find_client(mac);
    if (s >= 0) return s;
    if (pref != 0 && pool_holds(pref) && !addr_busy(pref)) begin
      s = take_slot(mac, pref, now);
      if (s >= 0) return s;
    end
    for (int off = 0; off < pool_cnt; off++) begin
      cand = {pool_base[31:8], 8'(pool_base[7:0] + off)};
      if (!addr_busy(cand)) return take_slot(mac, cand, now);
    end
    return -1;
  endfunction

  // updates the lease table; returns 1 when the request draws a reply
  function automatic bit predict_reply(dhcp_msg_t m, output reply_t r);
    int s;
    logic [31:0] wanted, age;
    r = '{kind: KindAck, ip: '0, mac: m.mac, xid: m.xid};
    if (!m.cmd) begin
      for (int i = 0; i < Slots; i++) begin
        age = m.now - lease_exp[i];
        if (lease_used[i] && !age[31]) lease_used[i] = 0;
      end
      return 0;
    end
    case (m.mt)
      MsgDiscover: begin
        s = assign_lease(m.mac, m.req, m.now);
        if (s < 0) return 0;
        lease_exp[s] = m.now + lease_len;
        r.kind = KindOffer;
        r.ip = lease_addr[s];
        return 1;
      end
      MsgRequest: begin
        wanted = (m.req != 0) ? m.req : m.ci;
        if (m.sid != 0 && m.sid != srv_ip) return 0;
        s = find_client(m.mac);
        if (s < 0) s = assign_lease(m.mac, wanted, m.now);
        if (s < 0 || (wanted != 0 && wanted != lease_addr[s])) begin
          r.kind = KindNak;
          return 1;
        end
        lease_exp[s] = m.now + lease_len;
        r.ip = lease_addr[s];
        return 1;
      end
      MsgDecline, MsgRelease: begin
        s = find_client(m.mac);
        if (s >= 0) lease_used[s] = 0;
        return 0;
      end
      MsgInform: begin
        r.ip = m.ci;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task automatic send_req(dhcp_msg_t m);
    repeat (pick_gap()) @(negedge clk_i);
    // offer only while the block is ready
    do @(negedge clk_i); while (!s_axis_tready);
    s_axis_tdata <= {m.xid, m.ci, m.sid, m.req, m.mac, m.mt, m.now};
    s_axis_tuser <= m.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    last_had_reply = predict_reply(m, last_reply);
    if (last_had_reply) due_replies.push_back(last_reply);
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegServerIp:  srv_ip = val;
      RegPoolStart: pool_base = val;
      RegPoolSize:  pool_cnt = val[7:0];
      default:      lease_len = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic setup_pool(logic [31:0] srv, logic [31:0] base, logic [7:0] cnt,
                            logic [31:0] len);
    wait_drained();
    cfg_write(RegServerIp, srv);
    cfg_write(RegPoolStart, base);
    cfg_write(RegPoolSize, {24'd0, cnt});
    cfg_write(RegLeaseMs, len);
  endtask

  function automatic dhcp_msg_t make_req(logic [7:0] mt, logic [47:0] mac, logic [31:0] req,
                                         logic [31:0] sid, logic [31:0] ci);
    dhcp_msg_t m;
    m = '{cmd: 1'b1, now: clock_ms, mt: mt, mac: mac, req: req, sid: sid, ci: ci,
          xid: $urandom};
    return m;
  endfunction

  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(0, Slots - 1);
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return {pool_base[31:8], 8'(pool_base[7:0] + $urandom_range(0, pool_cnt))};
      5:       return srv_ip;
      6, 7:    return lease_used[k] ? lease_addr[k] : '0;
      8:       return $urandom;
      default: return '1;
    endcase
  endfunction

  function automatic logic [31:0] pick_sid();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return $urandom;
      default: return srv_ip;
    endcase
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(0, 15) == 0) return 48'({$urandom, $urandom});
    return mac_set[$urandom_range(0, 39)];
  endfunction

  task automatic test_directed();
    logic [47:0] ma, mb, mc;
    dhcp_msg_t m;
    ma = '1;
    mb = 48'h0;
    mc = 48'h5A_A5_12_34_56_78;
    clock_ms = 32'hFFFF_FF00; // expiry stamps cross the wrap
    setup_pool(32'hC0A8_0101, 32'hC0A8_0164, 8'd3, 32'd1000);
    send_req(make_req(MsgDiscover, ma, 0, 0, 0));
    send_req(make_req(MsgRequest, ma, 32'hC0A8_0164, srv_ip, 0));
    send_req(make_req(MsgRequest, ma, 32'hC0A8_0165, 0, 0));   // wrong address: nak
    send_req(make_req(MsgRequest, ma, 0, 32'h0A0B_0C0D, 0));   // other server: silent
    send_req(make_req(MsgDiscover, mb, 32'hC0A8_0166, 0, 0));  // wanted address granted
    send_req(make_req(MsgDiscover, mc, 32'hC0A8_0101, 0, 0));  // server address refused
    send_req(make_req(MsgDiscover, 48'h1, 0, 0, 0));           // pool full: silent
    send_req(make_req(MsgRequest, 48'h1, 0, 0, 0));            // pool full: nak
    m = make_req(MsgInform, 48'h2, 0, 0, '1);
    m.xid = '1;
    send_req(m);
    send_req(make_req(MsgRelease, ma, 0, 0, 0));
    send_req(make_req(MsgDecline, mb, 0, 0, 0));
    send_req(make_req(MsgRelease, 48'h3, 0, 0, 0));            // unknown client
    send_req(make_req(8'd0, ma, 0, 0, 0));
    send_req(make_req(8'hFF, ma, 0, 0, 0));
    clock_ms += 2000;
    m = make_req(MsgDiscover, ma, '1, '1, '1);
    m.cmd = 1'b0;
    send_req(m);                                               // tick frees mc
    send_req(make_req(MsgRequest, mc, 0, srv_ip, 0));          // fresh lease, ack
    send_req(make_req(MsgRequest, 48'h4, 0, 0, 32'hC0A8_01C8)); // orphan lease, nak
    send_req(make_req(MsgDiscover, 48'h5, 0, 0, 0));
  endtask

  task automatic random_phase(int count);
    dhcp_msg_t m;
    int pick;
    for (int n = 0; n < count; n++) begin
      clock_ms += ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 150);
      pick = $urandom_range(0, 99);
      m = make_req(MsgDiscover, pick_mac(), pick_addr(), pick_sid(), pick_addr());
      if (pick < 30) begin
        // discover followed by the matching request
        m.sid = $urandom;
        send_req(m);
        if (last_had_reply) begin
          m.mt = MsgRequest;
          m.req = last_reply.ip;
          m.sid = srv_ip;
          m.xid = $urandom;
          m.now = clock_ms + $urandom_range(0, 20);
          send_req(m);
          n++;
        end
      end else begin
        if (pick < 45)      m.mt = MsgDiscover;
        else if (pick < 65) m.mt = MsgRequest;
        else if (pick < 71) m.mt = MsgRelease;
        else if (pick < 75) m.mt = MsgDecline;
        else if (pick < 81) m.mt = MsgInform;
        else if (pick < 86) m.mt = 8'($urandom);
        else                m.cmd = 1'b0;
        send_req(m);
      end
    end
  endtask

  task automatic test_random();
    setup_pool(32'hC0A8_0101, 32'hC0A8_0164, 8'd8, 32'd400);
    random_phase(200);
    setup_pool(32'h0, 32'h0A00_0000, 8'd0, 32'd0);            // empty pool
    random_phase(150);
    setup_pool('1, 32'hFFFF_FF00, 8'd255, '1);                 // extreme registers
    random_phase(200);
    quiet = 1;
    setup_pool(32'h0A00_00FE, 32'h0A00_00C8, 8'd100, 32'd300); // pool wraps the octet
    random_phase(200);
    quiet = 0;
    setup_pool(32'hC0A8_0001, 32'hC0A8_0002, 8'd40, 32'd2000); // more pool than slots
    random_phase(200);
    setup_pool(32'h7F00_0001, 32'h7F00_0010, 8'd16, 32'h8000_0000);
    random_phase(200);
  endtask

  task automatic test_backpressure();
    dhcp_msg_t m;
    wait_drained();
    rx_hold = 1;
    for (int n = 0; n < 15; n++) begin
      m = make_req(MsgInform, pick_mac(), 0, 0, $urandom);
      send_req(m);
    end
    // let every reply out before going on
    while (due_replies.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 15; n++) begin
      clock_ms += 10;
      send_req(make_req(MsgRequest, pick_mac(), pick_addr(), srv_ip, 0));
    end
  endtask

  // receiver side: random ready, with one long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(negedge clk_i);
        rx_hold = 0;
        m_axis_tready <= 1'b1;
      end else if (pick_gap() != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      n_replies++;
      if (due_replies.size() == 0) begin
        $display("%0t: reply with none outstanding, got kind %0d ip %h", $time,
                 m_axis_tuser, m_axis_tdata[31:0]);
        n_err++;
      end else begin
        want = due_replies.pop_front();
        if (want.kind == KindNak) n_naks++;
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: reply_kind expected %0d actual %0d", $time, want.kind, m_axis_tuser);
          n_err++;
        end
        if (m_axis_tdata[31:0] !== want.ip) begin
          $display("%0t: your_ip expected %h actual %h", $time, want.ip, m_axis_tdata[31:0]);
          n_err++;
        end
        if (m_axis_tdata[79:32] !== want.mac) begin
          $display("%0t: reply_mac expected %h actual %h", $time, want.mac,
                   m_axis_tdata[79:32]);
          n_err++;
        end
        if (m_axis_tdata[111:80] !== want.xid) begin
          $display("%0t: reply_xid expected %h actual %h", $time, want.xid,
                   m_axis_tdata[111:80]);
          n_err++;
        end
      end
    end
  end

  // cycles without any handshake on any channel
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, %0d replies outstanding", $time, due_replies.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    srv_ip = '0;
    pool_base = '0;
    pool_cnt = '0;
    lease_len = '0;
    foreach (lease_used[i]) lease_used[i] = 0;
    foreach (mac_set[i]) mac_set[i] = 48'({$urandom, $urandom});
    mac_set[0] = '0;
    mac_set[1] = '1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    $display("Sent %0d requests over 7 pool settings, %0d replies checked (%0d naks),",
             n_sent, n_replies, n_naks);
    $display("including octet-wrapping pools, full tables, lease expiry and backpressure.");
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
